[design/aging_presence_table_unit_defines.svh]
// Assertion macros shared by the aging presence table modules.
// Plain text macros only; no dependencies.
`ifndef AGING_PRESENCE_TABLE_UNIT_DEFINES_SVH
`define AGING_PRESENCE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define APT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/apt_pkg.sv]
// Shared types, constants and the blink delay function for the aging
// presence table. No dependencies.
package apt_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned CD_W    = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned DELAY_W = 10;
  // Widest live count the delay function takes (up to 511 entries).
  localparam int unsigned NMAX_W  = 9;

  localparam logic [CD_W-1:0] REFRESH_RESET = 8'd60;

  localparam logic CMD_SIGHTING = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic commit;
  } apt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic rd_last;
    logic out_busy;
  } apt_sts_t;

  // Blink delay: 700-100*n below five, 300-50*(n-4) after, floored at zero.
  function automatic logic [DELAY_W-1:0] led_delay(input logic [NMAX_W-1:0] n);
    logic [DELAY_W-1:0] res;
    logic [3:0]         over;
    res  = '0;
    over = 4'(n[3:0] - 4'd4);
    if (n < 9'd5) begin
      res = 10'd700 - 10'(n[2:0]) * 10'd100;
    end else if (n < 9'd10) begin
      res = 10'd300 - 10'(over) * 10'd50;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

[design/aging_presence_table_unit.sv]
// Top level of the aging presence table: ties the sequencer to the datapath.
// Depends on apt_pkg, apt_ctrl and apt_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) transfers one item: cmd_i = 0 is a
//   badge sighting of badge_id_i, cmd_i = 1 is a one-second tick.
//   Output channel (out_valid_o/out_ready_i) transfers one result per item:
//   the live entry count and the blink delay in milliseconds.
//   Config channel (cfg_valid_i/cfg_ready_o) writes refresh_seconds; it is
//   always ready and should only be written while the block is idle.
// Timing:
//   One item at a time: the next item is taken only once the last one has
//   committed its result. The table is walked one entry per cycle through the
//   single read port of the entry memories.
// Reset:
//   All entries read as empty (ID 0, countdown 0) and refresh_seconds = 60.
// Stall:
//   The result waits in the output register; the next item may be taken and
//   walked meanwhile, and holds before commit until the register frees.
module aging_presence_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [apt_pkg::ID_W-1:0]    badge_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [apt_pkg::COUNT_W-1:0] active_count_o,
  output logic [apt_pkg::DELAY_W-1:0] led_delay_ms_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [apt_pkg::CD_W-1:0]    cfg_data_i
);

  apt_pkg::apt_cmd_t cmd;
  apt_pkg::apt_sts_t sts;

  assign cfg_ready_o = 1'b1;

  apt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  apt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cmd_in_i       (cmd_i),
    .badge_id_i     (badge_id_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .active_count_o (active_count_o),
    .led_delay_ms_o (led_delay_ms_o)
  );

endmodule

[design/apt_ctrl.sv]
// Sequencer for the aging presence table: accepts an item, walks the
// table, then commits and loads the result. Depends on apt_pkg.
`include "aging_presence_table_unit_defines.svh"

module apt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  apt_pkg::apt_sts_t sts_i,
  output apt_pkg::apt_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  // Decode commands from state and status.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:  cmd_o.capture = in_valid_i;
      ST_SCAN:  cmd_o.rd_en   = 1'b1;
      ST_DRAIN: cmd_o         = '0;
      ST_FIN:   cmd_o.commit  = !sts_i.out_busy;
      default:  cmd_o         = '0;
    endcase
  end

  // Advance through scan, drain and commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE:  if (in_valid_i) state_q <= ST_SCAN;
        ST_SCAN:  if (sts_i.rd_last) state_q <= ST_DRAIN;
        ST_DRAIN: state_q <= ST_FIN;
        ST_FIN:   if (!sts_i.out_busy) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  `APT_ASSERT_NXT(a_capture_scan, clk_i, rst_ni, cmd_o.capture, state_q == ST_SCAN,
                  "capture not followed by scan")
  `APT_ASSERT_NXT(a_last_drain, clk_i, rst_ni, (state_q == ST_SCAN) && sts_i.rd_last,
                  state_q == ST_DRAIN, "scan did not stop at last entry")
  `APT_ASSERT_IMP(a_cmd_excl, clk_i, rst_ni, 1'b1,
                  $onehot0({cmd_o.capture, cmd_o.rd_en, cmd_o.commit}),
                  "commands overlap")

endmodule

[design/apt_dp.sv]
// Datapath for the aging presence table: entry memories, scan pipeline,
// match/free search, live count and output register. Depends on apt_pkg.
`include "aging_presence_table_unit_defines.svh"

module apt_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apt_pkg::apt_cmd_t             cmd_i,
  output apt_pkg::apt_sts_t             sts_o,
  input  logic                          cmd_in_i,
  input  logic [apt_pkg::ID_W-1:0]      badge_id_i,
  input  logic                          cfg_we_i,
  input  logic [apt_pkg::CD_W-1:0]      cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [apt_pkg::COUNT_W-1:0]   active_count_o,
  output logic [apt_pkg::DELAY_W-1:0]   led_delay_ms_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // Entry storage; valid bits make unwritten entries read as zero.
  logic [apt_pkg::ID_W-1:0] id_mem [ENTRIES];
  logic [apt_pkg::CD_W-1:0] cd_mem [ENTRIES];
  logic [ENTRIES-1:0]       valid_q;

  logic                     cmd_q;
  logic [apt_pkg::ID_W-1:0] badge_q;
  logic [apt_pkg::CD_W-1:0] refresh_q;
  logic [IW-1:0]            rd_idx_q;
  logic [IW-1:0]            proc_idx_q;
  logic                     rdv_q;
  logic                     vld_rd_q;
  logic [apt_pkg::ID_W-1:0] id_rd_q;
  logic [apt_pkg::CD_W-1:0] cd_rd_q;
  logic [CW-1:0]            live_q, live_d;
  logic                     match_q, free_q;
  logic [IW-1:0]            match_idx_q, free_idx_q;
  logic                     match_nz_q;
  logic                     out_valid_q;
  logic [apt_pkg::COUNT_W-1:0] active_q;
  logic [apt_pkg::DELAY_W-1:0] delay_q;

  logic [apt_pkg::ID_W-1:0] eff_id;
  logic [apt_pkg::CD_W-1:0] eff_cd;
  logic                     eff_nz;
  logic                     we;
  logic                     we_id;
  logic [IW-1:0]            waddr;
  logic [apt_pkg::CD_W-1:0] wcd;
  logic [CW-1:0]            count_new;
  logic [apt_pkg::NMAX_W-1:0] count_wide;
  logic                     is_tick;

  assign is_tick = (cmd_q == apt_pkg::CMD_TICK);
  assign eff_id  = vld_rd_q ? id_rd_q : '0;
  assign eff_cd  = vld_rd_q ? cd_rd_q : '0;
  assign eff_nz  = (eff_cd != '0);

  assign sts_o.rd_last  = (rd_idx_q == IW'(ENTRIES - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // Select the single memory write: tick decrement during scan, or commit of a sighting.
  always_comb begin
    we    = 1'b0;
    we_id = 1'b0;
    waddr = proc_idx_q;
    wcd   = eff_cd - 1'b1;
    if (rdv_q && is_tick && eff_nz) begin
      we = 1'b1;
    end else if (cmd_i.commit && !is_tick) begin
      wcd = refresh_q;
      if (match_q) begin
        we    = 1'b1;
        we_id = 1'b1;
        waddr = match_idx_q;
      end else if (free_q) begin
        we    = 1'b1;
        we_id = 1'b1;
        waddr = free_idx_q;
      end
    end
  end

  // Count live entries on the fly; sightings adjust for the committed entry.
  always_comb begin
    live_d = live_q;
    if (rdv_q) begin
      if (is_tick) begin
        live_d = live_q + CW'(eff_cd > 8'd1);
      end else begin
        live_d = live_q + CW'(eff_nz);
      end
    end
    count_new = live_q;
    if (!is_tick) begin
      if (match_q) begin
        count_new = live_q - CW'(match_nz_q) + CW'(refresh_q != '0);
      end else if (free_q) begin
        count_new = live_q + CW'(refresh_q != '0);
      end
    end
    count_wide = apt_pkg::NMAX_W'(count_new);
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      cd_mem[waddr] <= wcd;
    end
    if (we_id) begin
      id_mem[waddr] <= badge_q;
    end
    if (cmd_i.rd_en) begin
      id_rd_q <= id_mem[rd_idx_q];
      cd_rd_q <= cd_mem[rd_idx_q];
    end
  end

  // Hold the item and search results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= cmd_in_i;
      badge_q <= badge_id_i;
    end
    if (rdv_q && !match_q && (eff_id == badge_q)) begin
      match_idx_q <= proc_idx_q;
      match_nz_q  <= eff_nz;
    end
    if (rdv_q && !free_q && !eff_nz) begin
      free_idx_q <= proc_idx_q;
    end
    if (cmd_i.commit) begin
      active_q <= (count_wide > 9'd31) ? 5'd31 : count_wide[apt_pkg::COUNT_W-1:0];
      delay_q  <= apt_pkg::led_delay(count_wide);
    end
  end

  // Control state: scan counters, flags, valid bits, config, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      refresh_q   <= apt_pkg::REFRESH_RESET;
      rd_idx_q    <= '0;
      proc_idx_q  <= '0;
      rdv_q       <= 1'b0;
      vld_rd_q    <= 1'b0;
      live_q      <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        refresh_q <= cfg_data_i;
      end
      if (we_id) begin
        valid_q[waddr] <= 1'b1;
      end
      rdv_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        vld_rd_q   <= valid_q[rd_idx_q];
        proc_idx_q <= rd_idx_q;
        rd_idx_q   <= rd_idx_q + 1'b1;
      end
      if (cmd_i.capture) begin
        rd_idx_q <= '0;
        live_q   <= '0;
        match_q  <= 1'b0;
        free_q   <= 1'b0;
      end else begin
        live_q <= live_d;
        if (rdv_q && (eff_id == badge_q)) begin
          match_q <= 1'b1;
        end
        if (rdv_q && !eff_nz) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign active_count_o = active_q;
  assign led_delay_ms_o = delay_q;

  `APT_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd_i.commit,
                  !(out_valid_q && !out_ready_i), "result loaded over pending one")
  `APT_ASSERT_NXT(a_read_pipe, clk_i, rst_ni, cmd_i.rd_en, rdv_q,
                  "read data stage not marked valid")
  `APT_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_q,
                  apt_pkg::NMAX_W'(active_q) <= apt_pkg::NMAX_W'(ENTRIES),
                  "live count above table size")

endmodule
